// File: sv/pfau_pkg.sv
// Shared types and constants for the prime field arithmetic unit.
package pfau_pkg;

  // Operation codes carried on in_kind
  localparam logic [2:0] KIND_ADD      = 3'd0;
  localparam logic [2:0] KIND_SUB      = 3'd1;
  localparam logic [2:0] KIND_MUL      = 3'd2;
  localparam logic [2:0] KIND_MONT     = 3'd3;
  localparam logic [2:0] KIND_INV      = 3'd4;
  localparam logic [2:0] KIND_INV_SCL  = 3'd5;

  // Halvings left undone by the scaled inverse
  localparam int SCALE_KEEP = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDSUB,
    ST_MUL,
    ST_MONT,
    ST_MONT_FIX,
    ST_INV,
    ST_INV_FIX,
    ST_INV_NEG,
    ST_HALVE,
    ST_DONE
  } state_t;

endpackage

// File: sv/prime_field_arithmetic_unit.sv
// Prime field arithmetic unit: add, subtract, multiply, Montgomery multiply, inverse, scaled inverse.
// The inverse takes k almost-inverse steps (k <= 2*WORD_BITS) and then k modular halvings,
// or down to SCALE_KEEP left for the scaled inverse. Errors go straight to the output word.
// One word is processed at a time; each multiply bit and each almost-inverse step uses
// the single shared add/compare datapath once or twice.
// The output register holds one finished word, so the next input is taken while it waits.
// Synchronous active-low reset clears control state and sets the modulus to 3.
module prime_field_arithmetic_unit #(
  parameter int WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [62:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [62:0] in_operand_a,
  input  logic [62:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [62:0] out_result,
  output logic        out_error
);
  import pfau_pkg::*;

  localparam int DW = WORD_BITS + 1;
  localparam int CW = $clog2(WORD_BITS + 1);
  localparam int KW = $clog2(2 * WORD_BITS + 1);

  state_t          state_r, state_nxt;
  logic [62:0]     mod_r;
  logic [2:0]      kind_r, kind_nxt;
  logic [DW-1:0]   x_r, x_nxt;      // accumulator / r
  logic [DW-1:0]   y_r, y_nxt;      // operand shift register / s
  logic [DW-1:0]   u_r, u_nxt;
  logic [DW-1:0]   v_r, v_nxt;
  logic [DW-1:0]   opa_r, opa_nxt;  // addend
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            ph_r, ph_nxt;
  logic            err_r, err_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [62:0]     out_result_r, out_result_nxt;
  logic            out_error_r, out_error_nxt;

  logic [DW-1:0]   p_w;
  logic            in_acc;
  logic            bad_in;

  assign p_w       = DW'(mod_r);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_result = out_result_r;
  assign out_error  = out_error_r;

  // Input screening on full field widths
  always_comb begin
    logic bad_mod;
    bad_mod = (mod_r < 63'd3) || !mod_r[0] || ((mod_r >> (WORD_BITS - 1)) != '0);
    bad_in  = bad_mod || (in_kind > KIND_INV_SCL) || (in_operand_a >= mod_r) ||
              ((in_kind <= KIND_MONT) && (in_operand_b >= mod_r)) ||
              ((in_kind inside {KIND_INV, KIND_INV_SCL}) &&
               (in_operand_a == '0));
  end

  // Modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= 63'd3;
    end else if (cfg_wr_en) begin
      mod_r <= cfg_wr_data;
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ph_r        <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ph_r        <= ph_nxt;
      err_r       <= err_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    u_r          <= u_nxt;
    v_r          <= v_nxt;
    opa_r        <= opa_nxt;
    cnt_r        <= cnt_nxt;
    k_r          <= k_nxt;
    out_result_r <= out_result_nxt;
    out_error_r  <= out_error_nxt;
  end

  // Sequencer and shared add/compare datapath
  always_comb begin
    logic [DW-1:0] t;
    logic [DW-1:0] d;
    logic [KW-1:0] keep;
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    u_nxt          = u_r;
    v_nxt          = v_r;
    opa_nxt        = opa_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    ph_nxt         = ph_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_result_nxt = out_result_r;
    out_error_nxt  = out_error_r;
    t    = '0;
    d    = '0;
    keep = (kind_r == KIND_INV_SCL) ? KW'(SCALE_KEEP) : '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt = in_kind;
          err_nxt  = bad_in;
          x_nxt    = '0;
          ph_nxt   = 1'b0;
          cnt_nxt  = CW'(WORD_BITS);
          k_nxt    = '0;
          if (bad_in) begin
            state_nxt = ST_DONE;
          end else begin
            case (in_kind)
              KIND_ADD, KIND_SUB: begin
                x_nxt     = DW'(in_operand_a);
                opa_nxt   = DW'(in_operand_b);
                state_nxt = ST_ADDSUB;
              end
              KIND_MUL: begin
                opa_nxt   = DW'(in_operand_a);
                y_nxt     = DW'(in_operand_b);
                state_nxt = ST_MUL;
              end
              KIND_MONT: begin
                opa_nxt   = DW'(in_operand_b);
                y_nxt     = DW'(in_operand_a);
                state_nxt = ST_MONT;
              end
              default: begin
                u_nxt     = p_w;
                v_nxt     = DW'(in_operand_a);
                y_nxt     = DW'(1);
                state_nxt = ST_INV;
              end
            endcase
          end
        end
      end

      ST_ADDSUB: begin
        if (kind_r == KIND_ADD) begin
          t     = x_r + opa_r;
          x_nxt = (t >= p_w) ? t - p_w : t;
        end else begin
          t     = x_r - opa_r;
          x_nxt = (x_r >= opa_r) ? t : t + p_w;
        end
        state_nxt = ST_DONE;
      end

      // MSB first: double and reduce, then add the next bit of b and reduce
      ST_MUL: begin
        if (!ph_r) begin
          d      = x_r << 1;
          x_nxt  = (d >= p_w) ? d - p_w : d;
          ph_nxt = 1'b1;
        end else begin
          t       = x_r + (y_r[WORD_BITS-1] ? opa_r : '0);
          x_nxt   = (t >= p_w) ? t - p_w : t;
          y_nxt   = y_r << 1;
          cnt_nxt = cnt_r - CW'(1);
          ph_nxt  = 1'b0;
          if (cnt_r == CW'(1)) state_nxt = ST_DONE;
        end
      end

      // LSB first: add b on bit of a, then make even and halve
      ST_MONT: begin
        if (!ph_r) begin
          t      = x_r + (y_r[0] ? opa_r : '0);
          x_nxt  = (t >= p_w) ? t - p_w : t;
          ph_nxt = 1'b1;
        end else begin
          t       = x_r + (x_r[0] ? p_w : '0);
          x_nxt   = t >> 1;
          y_nxt   = y_r >> 1;
          cnt_nxt = cnt_r - CW'(1);
          ph_nxt  = 1'b0;
          if (cnt_r == CW'(1)) state_nxt = ST_MONT_FIX;
        end
      end

      ST_MONT_FIX: begin
        x_nxt     = (x_r >= p_w) ? x_r - p_w : x_r;
        state_nxt = ST_DONE;
      end

      // Almost-inverse: one step per cycle; x holds r, y holds s
      ST_INV: begin
        if ((v_r == '0) || (k_r == KW'(2 * WORD_BITS))) begin
          state_nxt = ST_INV_FIX;
        end else begin
          k_nxt = k_r + KW'(1);
          if (!u_r[0]) begin
            u_nxt = u_r >> 1;
            y_nxt = y_r << 1;
          end else if (!v_r[0]) begin
            v_nxt = v_r >> 1;
            x_nxt = x_r << 1;
          end else if (u_r > v_r) begin
            d     = u_r - v_r;
            u_nxt = d >> 1;
            x_nxt = x_r + y_r;
            y_nxt = y_r << 1;
          end else begin
            d     = v_r - u_r;
            v_nxt = d >> 1;
            y_nxt = y_r + x_r;
            x_nxt = x_r << 1;
          end
        end
      end

      ST_INV_FIX: begin
        x_nxt     = (x_r >= p_w) ? x_r - p_w : x_r;
        state_nxt = ST_INV_NEG;
      end

      ST_INV_NEG: begin
        x_nxt     = p_w - x_r;
        state_nxt = ST_HALVE;
      end

      // Modular halving, repeated until k falls to the kept count
      ST_HALVE: begin
        if (k_r > keep) begin
          t     = x_r + (x_r[0] ? p_w : '0);
          x_nxt = t >> 1;
          k_nxt = k_r - KW'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = err_r ? '0 : 63'(x_r);
          out_error_nxt  = err_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_result_r == '0))
    else $error("error word carries nonzero result");

  a_u_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INV) |-> (u_r <= p_w))
    else $error("almost-inverse u exceeds modulus");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HALVE) |-> (k_r <= KW'(2 * WORD_BITS)))
    else $error("iteration count out of range");

  a_halve_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HALVE) |-> (x_r <= p_w))
    else $error("halving value not reduced");

endmodule
